/* rtl/sv39pte_pkg.sv */
`default_nettype none
package sv39pte_pkg;

  localparam int unsigned ENTRY_W = 54;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VPN_W   = 9;

  typedef enum logic [2:0] {
    CMD_MAP        = 3'd0,
    CMD_PROTECT    = 3'd1,
    CMD_PROTECT_U  = 3'd2,
    CMD_UNMAP      = 3'd3,
    CMD_UNMAP_U    = 3'd4,
    CMD_TRANSLATE  = 3'd5,
    CMD_TRANSLATE_U = 3'd6,
    CMD_UNKNOWN    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_MISALIGNED = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_DENIED     = 3'd3,
    STAT_EXHAUSTED  = 3'd4,
    STAT_CONFLICT   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_L2,
    S_E2,
    S_L1,
    S_E1,
    S_L0,
    S_E0,
    S_WR,
    S_DONE
  } state_t;

  localparam int unsigned B_V = 0;
  localparam int unsigned B_R = 1;
  localparam int unsigned B_W = 2;
  localparam int unsigned B_X = 3;
  localparam int unsigned B_U = 4;
  localparam int unsigned B_A = 6;
  localparam int unsigned B_D = 7;

endpackage
`default_nettype wire

/* rtl/sv39_page_table_engine_core.sv */
// Walk: each request makes up to three dependent table reads and up to three
//   table writes, all through a single-port table memory.
// Throughput: one request at a time; the next request is taken once the result
//   is loaded into the output register.
// Reset: synchronous; clears the table memory one entry per cycle, and no request
//   is accepted until the whole table is clear.
`default_nettype none
module sv39_page_table_engine_core #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [38:0] virt_addr,
  input  wire logic [55:0] phys_addr,
  input  wire logic        writable,
  input  wire logic        user,
  input  wire logic        executable,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [55:0]      result_addr
);

  localparam int unsigned DEPTH = TABLE_PAGES * 512;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned NFW   = PW + 1;
  localparam int unsigned EW    = sv39pte_pkg::ENTRY_W;

  sv39pte_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_addr;
  logic [NFW-1:0] nfp;
  logic           enable;
  logic [2:0]     cmd_q;
  logic [38:0]    va_q;
  logic [55:0]    pa_q;
  logic           wr_q, us_q, ex_q;
  logic [PW-1:0]  page_q;
  logic [2:0]     st_q;
  logic [55:0]    res_q;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [EW-1:0]  ram_wdata;
  logic [EW-1:0]  rd_data;

  sv39pte_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_data)
  );

  logic                          accept;
  logic                          out_load;
  logic                          is_map;
  logic                          need_u;
  logic                          misaligned;
  logic [2:0]                    st_early;
  logic                          e_v, e_rwx, e_table, e_leaf;
  logic [sv39pte_pkg::PPN_W-1:0] e_ppn;
  logic                          exhausted;
  logic                          l0_fail_nf, l0_denied;

  assign accept   = in_valid && !in_stall;
  assign out_load = (state == sv39pte_pkg::S_DONE) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  assign is_map = (cmd_q == sv39pte_pkg::CMD_MAP);
  assign need_u = (cmd_q == sv39pte_pkg::CMD_PROTECT_U) || (cmd_q == sv39pte_pkg::CMD_UNMAP_U)
                  || (cmd_q == sv39pte_pkg::CMD_TRANSLATE_U);

  assign e_v       = rd_data[sv39pte_pkg::B_V];
  assign e_rwx     = |rd_data[sv39pte_pkg::B_X:sv39pte_pkg::B_R];
  assign e_ppn     = rd_data[EW-1:10];
  assign e_table   = e_v && !e_rwx && (e_ppn < sv39pte_pkg::PPN_W'(TABLE_PAGES));
  assign e_leaf    = e_v && e_rwx;
  assign exhausted = (nfp >= NFW'(TABLE_PAGES));

  assign l0_fail_nf = !e_leaf;
  assign l0_denied  = (need_u && !rd_data[sv39pte_pkg::B_U])
                      || ((cmd_q == sv39pte_pkg::CMD_TRANSLATE
                           || cmd_q == sv39pte_pkg::CMD_TRANSLATE_U)
                          && wr_q && !rd_data[sv39pte_pkg::B_W]);

  always_comb begin
    misaligned = 1'b0;
    case (command)
      sv39pte_pkg::CMD_MAP:
        misaligned = (virt_addr[11:0] != 12'd0) || (phys_addr[11:0] != 12'd0);
      sv39pte_pkg::CMD_PROTECT, sv39pte_pkg::CMD_PROTECT_U,
      sv39pte_pkg::CMD_UNMAP, sv39pte_pkg::CMD_UNMAP_U:
        misaligned = (virt_addr[11:0] != 12'd0);
      default: misaligned = 1'b0;
    endcase
    if (!enable) begin
      st_early = sv39pte_pkg::STAT_NOT_FOUND;
    end else if (command == sv39pte_pkg::CMD_UNKNOWN) begin
      st_early = sv39pte_pkg::STAT_DENIED;
    end else if (misaligned) begin
      st_early = sv39pte_pkg::STAT_MISALIGNED;
    end else begin
      st_early = sv39pte_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sv39pte_pkg::S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = sv39pte_pkg::S_IDLE;
      end
      sv39pte_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (st_early == sv39pte_pkg::STAT_OK) ? sv39pte_pkg::S_L2
                                                          : sv39pte_pkg::S_DONE;
        end
      end
      sv39pte_pkg::S_L2: state_next = sv39pte_pkg::S_E2;
      sv39pte_pkg::S_E2: begin
        if (is_map && !e_v) begin
          state_next = exhausted ? sv39pte_pkg::S_DONE : sv39pte_pkg::S_L1;
        end else begin
          state_next = e_table ? sv39pte_pkg::S_L1 : sv39pte_pkg::S_DONE;
        end
      end
      sv39pte_pkg::S_L1: state_next = sv39pte_pkg::S_E1;
      sv39pte_pkg::S_E1: begin
        if (is_map && !e_v) begin
          state_next = exhausted ? sv39pte_pkg::S_DONE : sv39pte_pkg::S_WR;
        end else if (e_table) begin
          state_next = is_map ? sv39pte_pkg::S_WR : sv39pte_pkg::S_L0;
        end else begin
          state_next = sv39pte_pkg::S_DONE;
        end
      end
      sv39pte_pkg::S_L0: state_next = sv39pte_pkg::S_E0;
      sv39pte_pkg::S_E0: state_next = sv39pte_pkg::S_DONE;
      sv39pte_pkg::S_WR: state_next = sv39pte_pkg::S_DONE;
      sv39pte_pkg::S_DONE: begin
        if (out_load) state_next = sv39pte_pkg::S_IDLE;
      end
      default: state_next = sv39pte_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = (state != sv39pte_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_addr  = {page_q, va_q[20:12]};
    ram_wdata = '0;
    unique case (state)
      sv39pte_pkg::S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      sv39pte_pkg::S_L2, sv39pte_pkg::S_E2: begin
        ram_addr  = {PW'(0), va_q[38:30]};
        ram_we    = (state == sv39pte_pkg::S_E2) && is_map && !e_v && !exhausted;
        ram_wdata = {sv39pte_pkg::PPN_W'(nfp[PW-1:0]), 10'd1};
      end
      sv39pte_pkg::S_L1, sv39pte_pkg::S_E1: begin
        ram_addr  = {page_q, va_q[29:21]};
        ram_we    = (state == sv39pte_pkg::S_E1) && is_map && !e_v && !exhausted;
        ram_wdata = {sv39pte_pkg::PPN_W'(nfp[PW-1:0]), 10'd1};
      end
      sv39pte_pkg::S_E0: begin
        ram_we = !l0_fail_nf && !l0_denied
                 && (cmd_q != sv39pte_pkg::CMD_TRANSLATE)
                 && (cmd_q != sv39pte_pkg::CMD_TRANSLATE_U);
        if (cmd_q == sv39pte_pkg::CMD_PROTECT || cmd_q == sv39pte_pkg::CMD_PROTECT_U) begin
          ram_wdata = rd_data;
          ram_wdata[sv39pte_pkg::B_W] = wr_q;
          ram_wdata[sv39pte_pkg::B_X] = ex_q;
          if (wr_q) ram_wdata[sv39pte_pkg::B_D] = 1'b1;
        end
      end
      sv39pte_pkg::S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {pa_q[55:12], 2'b00, 1'b1, 1'b1, 1'b0, us_q, ex_q, wr_q, 1'b1, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sv39pte_pkg::S_CLEAR;
      clr_addr <= '0;
      nfp      <= NFW'(1);
      enable   <= 1'b1;
    end else begin
      state <= state_next;
      if (state == sv39pte_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_valid && cfg_ready) enable <= cfg_data;
      if ((state == sv39pte_pkg::S_E2 || state == sv39pte_pkg::S_E1)
          && is_map && !e_v && !exhausted) begin
        nfp <= nfp + NFW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sv39pte_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q <= command;
          va_q  <= virt_addr;
          pa_q  <= phys_addr;
          wr_q  <= writable;
          us_q  <= user;
          ex_q  <= executable;
          st_q  <= st_early;
          res_q <= '0;
        end
      end
      sv39pte_pkg::S_E2, sv39pte_pkg::S_E1: begin
        if (is_map && !e_v) begin
          if (exhausted) st_q <= sv39pte_pkg::STAT_EXHAUSTED;
          else page_q <= nfp[PW-1:0];
        end else if (e_table) begin
          page_q <= e_ppn[PW-1:0];
        end else begin
          st_q <= is_map ? sv39pte_pkg::STAT_CONFLICT : sv39pte_pkg::STAT_NOT_FOUND;
        end
      end
      sv39pte_pkg::S_E0: begin
        if (l0_fail_nf) begin
          st_q <= sv39pte_pkg::STAT_NOT_FOUND;
        end else if (l0_denied) begin
          st_q <= sv39pte_pkg::STAT_DENIED;
        end else if (cmd_q == sv39pte_pkg::CMD_UNMAP || cmd_q == sv39pte_pkg::CMD_UNMAP_U) begin
          res_q <= {e_ppn, 12'd0};
        end else if (cmd_q == sv39pte_pkg::CMD_TRANSLATE
                     || cmd_q == sv39pte_pkg::CMD_TRANSLATE_U) begin
          res_q <= {e_ppn, va_q[11:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= st_q;
      result_addr <= (st_q == sv39pte_pkg::STAT_OK) ? res_q : '0;
    end
  end

  a_nfp_bound: assert property (@(posedge clk) disable iff (rst)
    nfp <= NFW'(TABLE_PAGES))
    else $error("free page counter past pool size");

  a_write_alloc: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != sv39pte_pkg::S_CLEAR) |-> (NFW'(ram_addr[AW-1:9]) < nfp))
    else $error("write into unallocated table page");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != sv39pte_pkg::STAT_OK) |-> (result_addr == 56'd0))
    else $error("nonzero address on failed request");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != sv39pte_pkg::S_IDLE) && (state != sv39pte_pkg::S_CLEAR))
    else $error("request accepted without starting a walk");

endmodule
`default_nettype wire

/* rtl/sv39pte_ram.sv */
`default_nettype none
module sv39pte_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import sv39pte_pkg::*;

  localparam int unsigned POOL_PAGES = 64;
  localparam int unsigned WATCHDOG_LIMIT = 120000;

  typedef struct packed {
    cmd_t cmd;
    logic [38:0] va;
    logic [55:0] pa;
    logic w;
    logic u;
    logic x;
  } pt_request_t;

  class pt_scoreboard;
    bit [53:0] pte_mem [int];
    int unsigned next_page;
    bit enabled;
    status_t want_status [$];
    bit [55:0] want_addr [$];
    int mismatches;
    int checked;

    function new();
      next_page = 1;
      enabled = 1;
      mismatches = 0;
      checked = 0;
    endfunction

    function bit [53:0] rd(int slot);
      return pte_mem.exists(slot) ? pte_mem[slot] : '0;
    endfunction

    function bit is_table(bit [53:0] e);
      return e[B_V] && e[3:1] == 3'b000 && e[53:10] < POOL_PAGES;
    endfunction

    function bit is_leaf(bit [53:0] e);
      return e[B_V] && e[3:1] != 3'b000;
    endfunction

    function status_t descend(int parent, bit [8:0] idx, output int child);
      int slot;
      bit [53:0] e;
      slot = parent * 512 + int'(idx);
      e = rd(slot);
      child = 0;
      if (!e[B_V]) begin
        if (next_page >= POOL_PAGES) return STAT_EXHAUSTED;
        child = next_page;
        next_page++;
        pte_mem[slot] = {44'(child), 10'h001};
        return STAT_OK;
      end
      if (!is_table(e)) return STAT_CONFLICT;
      child = int'(e[53:10]);
      return STAT_OK;
    endfunction

    function bit find_leaf(bit [38:0] va, output int slot);
      bit [53:0] e;
      int page;
      slot = 0;
      e = rd(int'(va[38:30]));
      if (!is_table(e)) return 0;
      page = int'(e[53:10]);
      e = rd(page * 512 + int'(va[29:21]));
      if (!is_table(e)) return 0;
      page = int'(e[53:10]);
      slot = page * 512 + int'(va[20:12]);
      return is_leaf(rd(slot));
    endfunction

    function void note_request(pt_request_t r);
      status_t st;
      bit [55:0] res;
      bit [53:0] e;
      int l1;
      int l0;
      int slot;
      st = STAT_OK;
      res = '0;
      if (!enabled) begin
        st = STAT_NOT_FOUND;
      end else if (r.cmd == CMD_MAP) begin
        if (r.va[11:0] != 0 || r.pa[11:0] != 0) begin
          st = STAT_MISALIGNED;
        end else begin
          st = descend(0, r.va[38:30], l1);
          if (st == STAT_OK) st = descend(l1, r.va[29:21], l0);
          if (st == STAT_OK) begin
            e = {r.pa[55:12], 10'h0};
            e[B_V] = 1; e[B_R] = 1; e[B_A] = 1; e[B_D] = 1;
            e[B_W] = r.w; e[B_U] = r.u; e[B_X] = r.x;
            pte_mem[l0 * 512 + int'(r.va[20:12])] = e;
          end
        end
      end else if (r.cmd inside {CMD_PROTECT, CMD_PROTECT_U, CMD_UNMAP, CMD_UNMAP_U}) begin
        if (r.va[11:0] != 0) begin
          st = STAT_MISALIGNED;
        end else if (!find_leaf(r.va, slot)) begin
          st = STAT_NOT_FOUND;
        end else begin
          e = rd(slot);
          if ((r.cmd == CMD_PROTECT_U || r.cmd == CMD_UNMAP_U) && !e[B_U]) begin
            st = STAT_DENIED;
          end else if (r.cmd == CMD_PROTECT || r.cmd == CMD_PROTECT_U) begin
            e[B_W] = r.w;
            if (r.w) e[B_D] = 1;
            e[B_X] = r.x;
            pte_mem[slot] = e;
          end else begin
            res = {e[53:10], 12'h0};
            pte_mem[slot] = '0;
          end
        end
      end else if (r.cmd == CMD_TRANSLATE || r.cmd == CMD_TRANSLATE_U) begin
        if (!find_leaf(r.va, slot)) begin
          st = STAT_NOT_FOUND;
        end else begin
          e = rd(slot);
          if ((r.cmd == CMD_TRANSLATE_U && !e[B_U]) || (r.w && !e[B_W])) st = STAT_DENIED;
          else res = {e[53:10], r.va[11:0]};
        end
      end else begin
        st = STAT_DENIED;
      end
      want_status.push_back(st);
      want_addr.push_back(st == STAT_OK ? res : 56'h0);
    endfunction

    function void flag(string what, int es, bit [55:0] ea, int gs, bit [55:0] ga);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected status %0d addr %h, got status %0d addr %h",
                 what, es, ea, gs, ga);
    endfunction

    function void check_result(logic [2:0] st, logic [55:0] addr);
      status_t es;
      bit [55:0] ea;
      checked++;
      if (want_status.size() == 0) begin
        flag("unexpected result", 0, 0, st, addr);
        return;
      end
      es = want_status.pop_front();
      ea = want_addr.pop_front();
      if (st !== es || addr !== ea) flag("result", es, ea, st, addr);
    endfunction

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_data = 0;
  logic in_valid = 0;
  logic out_stall = 0;
  pt_request_t req_q = '0;
  wire cfg_ready;
  wire in_stall;
  wire out_valid;
  wire [2:0] status;
  wire [55:0] result_addr;

  pt_scoreboard sb = new();
  int hold_token = 0;
  int hold_seen = 0;
  int rx_hold = 0;
  bit tx_quiet = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  sv39_page_table_engine_core #(.TABLE_PAGES(POOL_PAGES)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(req_q.cmd), .virt_addr(req_q.va), .phys_addr(req_q.pa),
    .writable(req_q.w), .user(req_q.u), .executable(req_q.x),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_addr(result_addr)
  );

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      rx_hold <= 400;
      out_stall <= 1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1;
    end else if (sb.checked >= 250 && sb.checked < 400) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(req_q);
      if (out_valid && !out_stall) sb.check_result(status, result_addr);
      if (cfg_valid && cfg_ready) sb.enabled = cfg_data;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("sv39_page_table_engine_core test failed");
        $finish;
      end
    end
  end

  task automatic send_request(pt_request_t r);
    if (!tx_quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_q <= r;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(bit v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic pt_request_t make(cmd_t c, logic [38:0] va, logic [55:0] pa,
                                       bit w, bit u, bit x);
    pt_request_t r;
    r.cmd = c; r.va = va; r.pa = pa; r.w = w; r.u = u; r.x = x;
    return r;
  endfunction

  function automatic pt_request_t random_request(bit wide);
    pt_request_t r;
    int pick;
    logic [8:0] v2;
    logic [8:0] v1;
    logic [8:0] v0;
    pick = $urandom_range(0, 99);
    if (pick < 33) r.cmd = CMD_MAP;
    else if (pick < 98) r.cmd = cmd_t'($urandom_range(1, 6));
    else r.cmd = CMD_UNKNOWN;
    case ($urandom_range(0, 3))
      0: v2 = 9'd0;
      1: v2 = 9'd1;
      2: v2 = 9'd2;
      default: v2 = 9'h1ff;
    endcase
    case ($urandom_range(0, 2))
      0: v1 = 9'd0;
      1: v1 = 9'd5;
      default: v1 = 9'h1ff;
    endcase
    v0 = ($urandom_range(0, 9) == 0) ? 9'h1ff : 9'($urandom_range(0, 15));
    if (wide || $urandom_range(0, 99) < 5) begin
      v2 = 9'($urandom); v1 = 9'($urandom); v0 = 9'($urandom);
    end
    r.va = {v2, v1, v0, 12'h0};
    if (r.cmd inside {CMD_TRANSLATE, CMD_TRANSLATE_U} || $urandom_range(0, 99) < 4)
      r.va[11:0] = 12'($urandom);
    r.pa = {24'($urandom), 20'($urandom), 12'h0};
    if ($urandom_range(0, 99) < 4) r.pa[11:0] = 12'($urandom);
    r.w = 1'($urandom_range(0, 1));
    r.u = ($urandom_range(0, 3) != 0);
    r.x = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic random_burst(int n, bit wide);
    for (int i = 0; i < n; i++) begin
      tx_quiet = (i >= 150 && i < 250);
      if (i == 100) hold_token++;
      send_request(random_request(wide));
    end
    tx_quiet = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    write_enable(1);
    send_request(make(CMD_MAP, 39'h0, 56'hff_ffff_ffff_f000, 1, 1, 1));
    send_request(make(CMD_TRANSLATE_U, 39'hfff, 56'h0, 1, 0, 0));
    send_request(make(CMD_MAP, 39'h7f_ffff_f000, 56'h0, 0, 0, 0));
    send_request(make(CMD_TRANSLATE, 39'h7f_ffff_ffff, 56'h0, 1, 0, 0));
    send_request(make(CMD_TRANSLATE, 39'h7f_ffff_f123, 56'h0, 0, 0, 0));
    send_request(make(CMD_TRANSLATE_U, 39'h7f_ffff_f000, 56'h0, 0, 0, 0));
    send_request(make(CMD_PROTECT_U, 39'h7f_ffff_f000, 56'h0, 1, 0, 1));
    send_request(make(CMD_UNMAP_U, 39'h7f_ffff_f000, 56'h0, 0, 0, 0));
    send_request(make(CMD_PROTECT, 39'h7f_ffff_f000, 56'h0, 1, 0, 1));
    send_request(make(CMD_TRANSLATE, 39'h7f_ffff_f001, 56'h0, 1, 0, 0));
    send_request(make(CMD_PROTECT_U, 39'h0, 56'h0, 0, 0, 0));
    send_request(make(CMD_TRANSLATE, 39'h10, 56'h0, 1, 0, 0));
    send_request(make(CMD_UNMAP, 39'h7f_ffff_f000, 56'h0, 0, 0, 0));
    send_request(make(CMD_TRANSLATE, 39'h7f_ffff_f000, 56'h0, 0, 0, 0));
    send_request(make(CMD_UNMAP_U, 39'h0, 56'h0, 0, 0, 0));
    send_request(make(CMD_MAP, 39'h1234, 56'h5000, 1, 1, 1));
    send_request(make(CMD_MAP, 39'h2000, 56'h5001, 1, 1, 1));
    send_request(make(CMD_PROTECT, 39'h2001, 56'h0, 0, 0, 0));
    send_request(make(CMD_UNMAP, 39'h2800, 56'h0, 0, 0, 0));
    send_request(make(CMD_TRANSLATE, 39'h40_0000_0000, 56'h0, 0, 0, 0));
    send_request(make(CMD_UNKNOWN, 39'h0, 56'h0, 1, 1, 1));
    random_burst(340, 0);
    drain();
    write_enable(0);
    random_burst(30, 0);
    drain();
    write_enable(1);
    random_burst(330, 0);
    random_burst(90, 1);
    drain();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("sv39_page_table_engine_core test passed");
    else
      $display("sv39_page_table_engine_core test failed");
    $finish;
  end
endmodule
